// ----- rtl/tgarle_pkg.sv -----
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared constants, types and helpers of the run-length pixel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tgarle_pkg;

  // Largest image side in pixels; larger settings are clamped to it
  localparam int unsigned MaxDim   = 4096;
  // Width of a dimension register
  localparam int unsigned DimW     = 13;
  // Row and column counters (values below MaxDim)
  localparam int unsigned CoordW   = $clog2(MaxDim);
  // Pixels left in the image, up to MaxDim * MaxDim
  localparam int unsigned TotW     = $clog2(MaxDim * MaxDim + 1);
  // Repeat count of one result
  localparam int unsigned CountW   = 8;
  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_ALPHA  = 3'd2,
    CFG_FLIP   = 3'd3,
    CFG_RLE    = 3'd4
  } cfg_idx_e;

  // Effective configuration seen by the datapath
  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic            has_alpha;
    logic            flip_rows;
    logic            rle_mode;
    logic [TotW-1:0] total;
  } cfg_t;

  // Command from the parser to the position tracker
  typedef struct packed {
    logic              restart;
    logic              step;
    logic [CountW-1:0] count;
  } pos_cmd_t;

  // Status of the position tracker
  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [TotW-1:0]   remaining;
    logic              busy;
  } pos_sts_t;

  // One decoded pixel or run
  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
    logic [CountW-1:0] repeat_count;
    logic [11:0]       start_row;
    logic [11:0]       start_column;
    logic              image_end;
    logic              overrun;
  } result_t;

  // Zero reads as one, anything above MaxDim as MaxDim
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimW'(MaxDim)) begin
      r = DimW'(MaxDim);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tga_rle_pixel_decoder.sv -----
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Run-length / raw pixel stream decoder for 24- and 32-bit true-color images.
// ----------------------------------------------------------------------------
//  channel  | signals                                 | carries
//  ---------+-----------------------------------------+--------------------------
//  in       | in_valid_i  in_ready_o   data_byte_i    | one stream byte
//  out      | out_valid_o out_ready_i  red_o..overrun_o | one pixel or run
//  cfg      | cfg_valid_i cfg_ready_o  cfg_index_i,    | register write
//           |                          cfg_data_i      |
//
//  One byte per cycle unless held by a full output, the divider or a total
//  load; a byte passes the input register and the parser to the output
//  register. A run that wraps past more than one row end (width below 128)
//  holds the input while the bit-serial divider settles row and column.
//  The cycle after a register write the input is held to load the pixel total.
//  Reset is asynchronous; it restores the register defaults and the parser.
//  A stalled output keeps taking bytes until its skid entry is filled.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input stream
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [7:0]                      data_byte_i,
  // results
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [7:0]                           red_o,
  output logic [7:0]                           green_o,
  output logic [7:0]                           blue_o,
  output logic [7:0]                           alpha_o,
  output logic [7:0]                           repeat_count_o,
  output logic [11:0]                          start_row_o,
  output logic [11:0]                          start_column_o,
  output logic                                 image_end_o,
  output logic                                 overrun_o,
  // configuration
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [tgarle_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [tgarle_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned NW = tgarle_pkg::CountW;

  typedef enum logic {
    PH_HEADER = 1'b0,
    PH_PIXEL  = 1'b1
  } phase_e;

  tgarle_pkg::cfg_t     cfg;
  tgarle_pkg::pos_cmd_t pcmd;
  tgarle_pkg::pos_sts_t psts;
  tgarle_pkg::result_t  res;
  tgarle_pkg::result_t  res_out;
  logic                 cfg_restart;
  logic                 cfg_reload;
  logic                 space;

  // Input register
  logic       in_v_q;
  logic [7:0] in_b_q;
  logic       adv;

  // Parser state
  phase_e         phase_q, phase_d;
  logic [NW-1:0]  left_q, left_d;
  logic           run_q, run_d;
  logic [1:0]     bidx_q, bidx_d;
  logic [23:0]    pix_q, pix_d;

  // Per-item decode
  logic           is_header;
  logic           complete;
  logic [NW-1:0]  want;
  logic           too_many;
  logic [NW-1:0]  n;
  logic           img_end;
  logic           over;
  logic [tgarle_pkg::DimW-1:0] flip_row;
  logic           push;

  tgarle_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .restart_o   (cfg_restart),
    .reload_o    (cfg_reload)
  );

  assign cfg_ready_o = 1'b1;

  // Input stage
  assign adv        = in_v_q && space && !psts.busy && !cfg_reload;
  assign in_ready_o = !in_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_b_q <= data_byte_i;
    end
  end

  // Header / pixel classification
  assign is_header = cfg.rle_mode && (phase_q == PH_HEADER);
  assign complete  = !is_header && (bidx_q == (cfg.has_alpha ? 2'd3 : 2'd2));

  // Repeat count, clipped to the pixels left in the image
  always_comb begin
    want = (cfg.rle_mode && run_q) ? left_q : NW'(1);
    if (want == '0) begin
      want = NW'(1);
    end
  end

  assign too_many = tgarle_pkg::TotW'(want) > psts.remaining;
  assign n        = too_many ? psts.remaining[NW-1:0] : want;
  assign img_end  = tgarle_pkg::TotW'(n) == psts.remaining;
  assign over     = too_many ||
                    (cfg.rle_mode && img_end && !run_q && (left_q > NW'(1)));
  assign flip_row = cfg.height - tgarle_pkg::DimW'(1) - tgarle_pkg::DimW'(psts.row);

  // Result fields
  assign res.red          = cfg.has_alpha ? pix_q[23:16] : in_b_q;
  assign res.green        = pix_q[15:8];
  assign res.blue         = pix_q[7:0];
  assign res.alpha        = cfg.has_alpha ? in_b_q : 8'd0;
  assign res.repeat_count = n;
  assign res.start_row    = cfg.flip_rows ? flip_row[11:0] : psts.row;
  assign res.start_column = psts.col;
  assign res.image_end    = img_end;
  assign res.overrun      = over;

  assign push = adv && complete;

  // Parser next state
  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    run_d   = run_q;
    bidx_d  = bidx_q;
    pix_d   = pix_q;
    if (cfg_restart) begin
      phase_d = PH_HEADER;
      left_d  = '0;
      run_d   = 1'b0;
      bidx_d  = '0;
      pix_d   = '0;
    end else if (adv) begin
      if (is_header) begin
        run_d   = in_b_q[7];
        left_d  = in_b_q[7] ? (in_b_q - 8'd127) : (in_b_q + 8'd1);
        phase_d = PH_PIXEL;
        bidx_d  = '0;
        pix_d   = '0;
      end else if (!complete) begin
        case (bidx_q)
          2'd0:    pix_d[7:0]   = in_b_q;
          2'd1:    pix_d[15:8]  = in_b_q;
          default: pix_d[23:16] = in_b_q;
        endcase
        bidx_d = bidx_q + 2'd1;
      end else begin
        bidx_d = '0;
        pix_d  = '0;
        if (img_end) begin
          phase_d = PH_HEADER;
          left_d  = '0;
          run_d   = 1'b0;
        end else if (cfg.rle_mode) begin
          if (run_q) begin
            left_d = '0;
          end else begin
            left_d = (left_q > '0) ? left_q - NW'(1) : '0;
          end
          if (left_d == '0) begin
            phase_d = PH_HEADER;
            run_d   = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      left_q  <= '0;
      run_q   <= 1'b0;
      bidx_q  <= '0;
      pix_q   <= '0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      run_q   <= run_d;
      bidx_q  <= bidx_d;
      pix_q   <= pix_d;
    end
  end

  // Position tracker
  assign pcmd.restart = cfg_restart || (push && img_end);
  assign pcmd.step    = push && !img_end;
  assign pcmd.count   = n;

  tgarle_pos u_pos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .reload_i (cfg_reload),
    .cmd_i    (pcmd),
    .sts_o    (psts)
  );

  // Result buffer
  tgarle_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (res_out)
  );

  assign red_o          = res_out.red;
  assign green_o        = res_out.green;
  assign blue_o         = res_out.blue;
  assign alpha_o        = res_out.alpha;
  assign repeat_count_o = res_out.repeat_count;
  assign start_row_o    = res_out.start_row;
  assign start_column_o = res_out.start_column;
  assign image_end_o    = res_out.image_end;
  assign overrun_o      = res_out.overrun;

endmodule

`default_nettype wire

// ----- rtl/tgarle_cfg.sv -----
// ----------------------------------------------------------------------------
// tgarle_cfg
// Configuration registers, dimension clamping and pixel total of the image.
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [tgarle_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [tgarle_pkg::CfgDataW-1:0] cfg_data_i,
  output tgarle_pkg::cfg_t                   cfg_o,
  output logic                               restart_o,
  output logic                               reload_o
);

  logic [tgarle_pkg::DimW-1:0] width_q, width_d;
  logic [tgarle_pkg::DimW-1:0] height_q, height_d;
  logic                        alpha_q, alpha_d;
  logic                        flip_q, flip_d;
  logic                        rle_q, rle_d;
  logic                        hit;
  logic                        reload_q;
  logic [tgarle_pkg::DimW-1:0] w_eff, h_eff;
  logic [2*tgarle_pkg::DimW-1:0] prod;

  // Register write decode; any known index restarts the decode
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    alpha_d  = alpha_q;
    flip_d   = flip_q;
    rle_d    = rle_q;
    hit      = 1'b0;
    if (cfg_valid_i) begin
      unique case (tgarle_pkg::cfg_idx_e'(cfg_index_i))
        tgarle_pkg::CFG_WIDTH: begin
          width_d = cfg_data_i[tgarle_pkg::DimW-1:0];
          hit     = 1'b1;
        end
        tgarle_pkg::CFG_HEIGHT: begin
          height_d = cfg_data_i[tgarle_pkg::DimW-1:0];
          hit      = 1'b1;
        end
        tgarle_pkg::CFG_ALPHA: begin
          alpha_d = cfg_data_i[0];
          hit     = 1'b1;
        end
        tgarle_pkg::CFG_FLIP: begin
          flip_d = cfg_data_i[0];
          hit    = 1'b1;
        end
        tgarle_pkg::CFG_RLE: begin
          rle_d = cfg_data_i[0];
          hit   = 1'b1;
        end
        default: hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= tgarle_pkg::DimW'(1);
      height_q <= tgarle_pkg::DimW'(1);
      alpha_q  <= 1'b0;
      flip_q   <= 1'b0;
      rle_q    <= 1'b1;
      reload_q <= 1'b0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      alpha_q  <= alpha_d;
      flip_q   <= flip_d;
      rle_q    <= rle_d;
      reload_q <= hit;
    end
  end

  // Clamped sides and pixel total (13 x 13 product)
  assign w_eff = tgarle_pkg::clamp_dim(width_q);
  assign h_eff = tgarle_pkg::clamp_dim(height_q);
  assign prod  = w_eff * h_eff;

  assign cfg_o.width     = w_eff;
  assign cfg_o.height    = h_eff;
  assign cfg_o.has_alpha = alpha_q;
  assign cfg_o.flip_rows = flip_q;
  assign cfg_o.rle_mode  = rle_q;
  assign cfg_o.total     = prod[tgarle_pkg::TotW-1:0];
  assign restart_o       = hit;
  assign reload_o        = reload_q;

endmodule

`default_nettype wire

// ----- rtl/tgarle_pos.sv -----
// ----------------------------------------------------------------------------
// tgarle_pos
// Destination row/column and pixels-left tracker, with a bit-serial divider
// for runs that wrap past more than one row end.
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_pos (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tgarle_pkg::cfg_t     cfg_i,
  input  wire logic                 reload_i,
  input  wire tgarle_pkg::pos_cmd_t cmd_i,
  output tgarle_pkg::pos_sts_t      sts_o
);

  localparam int unsigned CW = tgarle_pkg::CoordW;
  localparam int unsigned NW = tgarle_pkg::CountW;

  logic [CW-1:0]             row_q, row_d;
  logic [CW-1:0]             col_q, col_d;
  logic [tgarle_pkg::TotW-1:0] rem_pix_q, rem_pix_d;
  logic                      busy_q, busy_d;
  logic [2:0]                cnt_q, cnt_d;
  logic [NW-1:0]             dvd_q, dvd_d;
  logic [NW-1:0]             drem_q, drem_d;
  logic [NW-1:0]             quo_q, quo_d;

  logic [CW:0]               sum;
  logic [tgarle_pkg::DimW:0] w2;
  logic [NW-1:0]             wdiv;
  logic [NW-1:0]             shl;
  logic                      ge;
  logic [NW-1:0]             drem_nx;
  logic [NW-1:0]             quo_nx;

  assign sum  = {1'b0, col_q} + (CW+1)'(cmd_i.count);
  assign w2   = {cfg_i.width, 1'b0};
  assign wdiv = {1'b0, cfg_i.width[NW-2:0]};

  // One restoring division step: quotient bit from the shifted remainder
  assign shl     = {drem_q[NW-2:0], dvd_q[NW-1]};
  assign ge      = (shl >= wdiv);
  assign drem_nx = ge ? (shl - wdiv) : shl;
  assign quo_nx  = {quo_q[NW-2:0], ge};

  always_comb begin
    row_d     = row_q;
    col_d     = col_q;
    rem_pix_d = rem_pix_q;
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    dvd_d     = dvd_q;
    drem_d    = drem_q;
    quo_d     = quo_q;
    if (cmd_i.restart) begin
      row_d     = '0;
      col_d     = '0;
      rem_pix_d = cfg_i.total;
      busy_d    = 1'b0;
    end else if (reload_i) begin
      rem_pix_d = cfg_i.total;
    end else if (busy_q) begin
      // Divider iteration; finish after the last quotient bit
      dvd_d  = {dvd_q[NW-2:0], 1'b0};
      drem_d = drem_nx;
      quo_d  = quo_nx;
      cnt_d  = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        row_d  = row_q + CW'(quo_nx);
        col_d  = drem_nx[CW-1:0];
      end
    end else if (cmd_i.step) begin
      rem_pix_d = rem_pix_q - tgarle_pkg::TotW'(cmd_i.count);
      if (sum < cfg_i.width) begin
        col_d = sum[CW-1:0];
      end else if ({1'b0, sum} < w2) begin
        col_d = sum[CW-1:0] - cfg_i.width[CW-1:0];
        row_d = row_q + CW'(1);
      end else begin
        // Width below one run length: sum fits the divider's 8 bits
        busy_d = 1'b1;
        cnt_d  = '0;
        dvd_d  = sum[NW-1:0];
        drem_d = '0;
        quo_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      rem_pix_q <= tgarle_pkg::TotW'(1);
      busy_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      row_q     <= row_d;
      col_q     <= col_d;
      rem_pix_q <= rem_pix_d;
      busy_q    <= busy_d;
      cnt_q     <= cnt_d;
    end
  end

  // Divider datapath
  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    drem_q <= drem_d;
    quo_q  <= quo_d;
  end

  assign sts_o.row       = row_q;
  assign sts_o.col       = col_q;
  assign sts_o.remaining = rem_pix_q;
  assign sts_o.busy      = busy_q;

endmodule

`default_nettype wire

// ----- rtl/tgarle_obuf.sv -----
// ----------------------------------------------------------------------------
// tgarle_obuf
// Result register with one skid entry; space is reported from registers only.
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_obuf (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire tgarle_pkg::result_t data_i,
  output logic                     space_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output tgarle_pkg::result_t      data_o
);

  tgarle_pkg::result_t main_q;
  tgarle_pkg::result_t skid_q;
  logic                main_v_q;
  logic                skid_v_q;
  logic                pop;

  assign pop = main_v_q && out_ready_i;

  // Push is only issued while the skid entry is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (skid_v_q) begin
        if (pop) begin
          skid_v_q <= 1'b0;
        end
      end else if (main_v_q) begin
        if (!pop && push_i) begin
          skid_v_q <= 1'b1;
        end else if (pop && !push_i) begin
          main_v_q <= 1'b0;
        end
      end else if (push_i) begin
        main_v_q <= 1'b1;
      end
    end
  end

  // Payload moves
  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (main_v_q) begin
      if (pop && push_i) begin
        main_q <= data_i;
      end else if (push_i) begin
        skid_q <= data_i;
      end
    end else if (push_i) begin
      main_q <= data_i;
    end
  end

  assign space_o     = !skid_v_q;
  assign out_valid_o = main_v_q;
  assign data_o      = main_q;

endmodule

`default_nettype wire
